/* rtl/core/fmr_pkg.sv */
// ----------------------------------------------------------------------------
// fmr_pkg
// Shared types and codes of the framed message receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fmr_pkg;

	localparam int LEN_W = 7;

	localparam logic [1:0] KIND_STATUS = 2'd0;
	localparam logic [1:0] KIND_BYTE   = 2'd1;
	localparam logic [1:0] KIND_EMPTY  = 2'd2;

	localparam logic OP_BYTE  = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	localparam logic [1:0] REG_START  = 2'd0;
	localparam logic [1:0] REG_LEADIN = 2'd1;
	localparam logic [1:0] REG_OWN    = 2'd2;

	// one entry handed from the front to the back
	typedef struct packed {
		logic             is_drain;
		logic [1:0]       kind;
		logic             done;
		logic             drop;
		logic             ovf;
		logic [LEN_W-1:0] len;
		logic             is_local;
	} cmd_t;

endpackage

/* rtl/core/fmr_ram.sv */
// ----------------------------------------------------------------------------
// fmr_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fmr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/core/fmr_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// fmr_cmd_fifo
// Two-entry queue of commands between the parser and the result engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fmr_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  fmr_pkg::cmd_t push_data,
	output logic          full,
	input  logic          pop,
	output fmr_pkg::cmd_t pop_data,
	output logic          empty
);

	fmr_pkg::cmd_t mem_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    cnt_q;

	assign full     = (cnt_q == 2'd2);
	assign empty    = (cnt_q == 2'd0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

/* rtl/core/fmr_front.sv */
// ----------------------------------------------------------------------------
// fmr_front
// Accepts transactions, runs the frame parser, writes the message store and
// queues one command per transaction for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fmr_front #(
	parameter int STORE_DEPTH = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           operation,
	input  logic [7:0]                     rx_byte,
	input  logic                           cfg_we,
	input  logic [1:0]                     cfg_index,
	input  logic [7:0]                     cfg_data,
	output logic                           ram_we,
	output logic [$clog2(STORE_DEPTH)-1:0] ram_waddr,
	output logic [7:0]                     ram_wdata,
	output logic                           push,
	output fmr_pkg::cmd_t                  push_data,
	input  logic                           fifo_full,
	input  logic                           drain_done
);

	localparam int AW    = $clog2(STORE_DEPTH);
	localparam int LEN_W = fmr_pkg::LEN_W;
	localparam logic [LEN_W-1:0] DEPTH_L = LEN_W'(STORE_DEPTH);

	localparam logic [2:0] PH_START    = 3'd0;
	localparam logic [2:0] PH_LEADIN   = 3'd1;
	localparam logic [2:0] PH_TOADDR   = 3'd2;
	localparam logic [2:0] PH_FROMADDR = 3'd3;
	localparam logic [2:0] PH_COMMAND  = 3'd4;
	localparam logic [2:0] PH_LENGTH   = 3'd5;
	localparam logic [2:0] PH_DATA     = 3'd6;
	localparam logic [2:0] PH_CHECK    = 3'd7;

	logic [2:0]       ph_q, ph_d, ph_cur;
	logic [7:0]       dr_q, dr_d;
	logic [LEN_W-1:0] wp_q, wp_d, wp_cur, wp_inc;
	logic [LEN_W-1:0] len_q, len_d;
	logic             rec_q, rec_d;
	logic             pend_q, pend_d;
	logic             busy_q, busy_d;
	logic [7:0]       start_q, leadin_q, own_q, dest_q;
	logic             accept, ovf, store_en;
	fmr_pkg::cmd_t    cmd;

	assign in_ready  = !fifo_full && !busy_q;
	assign accept    = in_valid && in_ready;
	assign push      = accept;
	assign push_data = cmd;
	assign ram_we    = store_en;
	assign ram_waddr = wp_cur[AW-1:0];
	assign ram_wdata = rx_byte;

	always_comb begin
		ph_d     = ph_q;
		dr_d     = dr_q;
		wp_d     = wp_q;
		len_d    = len_q;
		rec_d    = rec_q;
		pend_d   = pend_q;
		busy_d   = busy_q;
		cmd      = '0;
		cmd.kind = fmr_pkg::KIND_STATUS;
		ovf      = 1'b0;
		store_en = 1'b0;
		ph_cur   = ph_q;
		wp_cur   = wp_q;
		wp_inc   = wp_q;
		if (drain_done) begin
			busy_d = 1'b0;
		end
		if (accept) begin
			if (operation == fmr_pkg::OP_DRAIN) begin
				pend_d = 1'b0;
				if (!pend_q || len_q == '0) begin
					cmd.kind = fmr_pkg::KIND_EMPTY;
				end else begin
					cmd.is_drain = 1'b1;
					cmd.kind     = fmr_pkg::KIND_BYTE;
					cmd.len      = len_q;
					cmd.is_local = (own_q != 8'd0) && (dest_q == own_q);
					busy_d       = 1'b1;
				end
			end else begin
				ovf = (wp_q >= DEPTH_L);
				if (ovf) begin
					ph_cur = PH_START;
					wp_cur = '0;
					rec_d  = 1'b0;
				end
				cmd.ovf = ovf;
				ph_d    = ph_cur;
				wp_d    = wp_cur;
				if (pend_q) begin
					ph_d     = PH_START;
					wp_d     = '0;
					cmd.drop = 1'b1;
				end else begin
					case (ph_cur)
						PH_START: begin
							ph_d = (rx_byte == start_q) ? PH_LEADIN : PH_START;
						end
						PH_LEADIN: begin
							ph_d = (rx_byte == leadin_q) ? PH_TOADDR : PH_START;
						end
						PH_TOADDR: begin
							rec_d = 1'b1;
							ph_d  = PH_FROMADDR;
						end
						PH_FROMADDR: begin
							ph_d = PH_COMMAND;
						end
						PH_COMMAND: begin
							ph_d = PH_LENGTH;
						end
						PH_LENGTH: begin
							dr_d = rx_byte;
							ph_d = (rx_byte != 8'd0) ? PH_DATA : PH_CHECK;
						end
						PH_DATA: begin
							dr_d = dr_q - 8'd1;
							if (dr_d == 8'd0) begin
								ph_d = PH_CHECK;
							end
						end
						default: begin
							store_en = (wp_cur < DEPTH_L);
							rec_d    = 1'b0;
							pend_d   = 1'b1;
							ph_d     = PH_START;
							cmd.done = 1'b1;
						end
					endcase
					if (rec_d && (wp_cur < DEPTH_L)) begin
						store_en = 1'b1;
					end
					wp_inc = wp_cur + LEN_W'(store_en);
					if (ph_cur == PH_CHECK) begin
						len_d = wp_inc;
						wp_d  = '0;
					end else begin
						wp_d = wp_inc;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q     <= PH_START;
			dr_q     <= 8'd0;
			wp_q     <= '0;
			len_q    <= '0;
			rec_q    <= 1'b0;
			pend_q   <= 1'b0;
			busy_q   <= 1'b0;
			start_q  <= 8'd0;
			leadin_q <= 8'd0;
			own_q    <= 8'd0;
		end else begin
			ph_q   <= ph_d;
			dr_q   <= dr_d;
			wp_q   <= wp_d;
			len_q  <= len_d;
			rec_q  <= rec_d;
			pend_q <= pend_d;
			busy_q <= busy_d;
			if (cfg_we) begin
				case (cfg_index)
					fmr_pkg::REG_START:  start_q  <= cfg_data;
					fmr_pkg::REG_LEADIN: leadin_q <= cfg_data;
					fmr_pkg::REG_OWN:    own_q    <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// destination byte kept aside for the local check
	always_ff @(posedge clk) begin
		if (store_en && wp_cur == '0) begin
			dest_q <= rx_byte;
		end
	end

endmodule

/* rtl/core/fmr_back.sv */
// ----------------------------------------------------------------------------
// fmr_back
// Takes queued commands, plays out status results and drains the message
// store into the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fmr_back #(
	parameter int STORE_DEPTH = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           fifo_empty,
	input  fmr_pkg::cmd_t                  fifo_data,
	output logic                           fifo_pop,
	output logic                           ram_re,
	output logic [$clog2(STORE_DEPTH)-1:0] ram_raddr,
	input  logic [7:0]                     ram_rdata,
	output logic                           drain_done,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [1:0]                     result_kind,
	output logic                           frame_done,
	output logic                           byte_dropped,
	output logic                           frame_overflow,
	output logic [7:0]                     message_byte,
	output logic [5:0]                     byte_position,
	output logic                           is_local,
	output logic                           last
);

	localparam int AW    = $clog2(STORE_DEPTH);
	localparam int LEN_W = fmr_pkg::LEN_W;

	logic             act_q;
	logic [LEN_W-1:0] n_q;
	logic [LEN_W-1:0] iss_q;
	logic             loc_q;
	logic             rd_s1;
	logic [LEN_W-1:0] rd_idx_s1;
	logic             rd_last_s1;
	logic             out_valid_q;
	logic             out_load, issue, load_byte, load_status;

	assign out_valid   = out_valid_q;
	assign out_load    = !out_valid_q || out_ready;
	assign issue       = act_q && (iss_q != n_q) && (!rd_s1 || out_load);
	assign load_byte   = rd_s1 && out_load;
	assign fifo_pop    = !fifo_empty && !act_q && (fifo_data.is_drain || out_load);
	assign load_status = fifo_pop && !fifo_data.is_drain;
	assign drain_done  = load_byte && rd_last_s1;
	assign ram_re      = issue;
	assign ram_raddr   = iss_q[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q       <= 1'b0;
			rd_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fifo_pop && fifo_data.is_drain) begin
				act_q <= 1'b1;
			end else if (drain_done) begin
				act_q <= 1'b0;
			end
			if (issue) begin
				rd_s1 <= 1'b1;
			end else if (out_load) begin
				rd_s1 <= 1'b0;
			end
			if (load_byte || load_status) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fifo_pop && fifo_data.is_drain) begin
			n_q   <= fifo_data.len;
			loc_q <= fifo_data.is_local;
			iss_q <= '0;
		end else if (issue) begin
			iss_q <= iss_q + LEN_W'(1);
		end
		if (issue) begin
			rd_idx_s1  <= iss_q;
			rd_last_s1 <= (iss_q + LEN_W'(1) == n_q);
		end
		if (load_byte) begin
			result_kind    <= fmr_pkg::KIND_BYTE;
			frame_done     <= 1'b0;
			byte_dropped   <= 1'b0;
			frame_overflow <= 1'b0;
			message_byte   <= ram_rdata;
			byte_position  <= rd_idx_s1[5:0];
			is_local       <= loc_q;
			last           <= rd_last_s1;
		end else if (load_status) begin
			result_kind    <= fifo_data.kind;
			frame_done     <= fifo_data.done;
			byte_dropped   <= fifo_data.drop;
			frame_overflow <= fifo_data.ovf;
			message_byte   <= 8'd0;
			byte_position  <= 6'd0;
			is_local       <= 1'b0;
			last           <= 1'b1;
		end
	end

endmodule

/* rtl/core/framed_message_receiver.sv */
// ----------------------------------------------------------------------------
// framed_message_receiver
// Received bytes: one per cycle while the queue has room and no drain runs; status result via
// queue and output register. Process: first byte via queue, store read and output register,
// then one byte per cycle while out_ready holds (single store read port); inputs wait for the last.
// Reset clears parser, pending flag and registers; store contents undefined.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module framed_message_receiver #(
	parameter int STORE_DEPTH = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       operation,
	input  logic [7:0] rx_byte,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] result_kind,
	output logic       frame_done,
	output logic       byte_dropped,
	output logic       frame_overflow,
	output logic [7:0] message_byte,
	output logic [5:0] byte_position,
	output logic       is_local,
	output logic       last
);

	localparam int AW = $clog2(STORE_DEPTH);

	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [7:0]    ram_wdata, ram_rdata;
	logic          push, pop, fifo_full, fifo_empty, drain_done;
	fmr_pkg::cmd_t push_data, pop_data;

	fmr_front #(.STORE_DEPTH(STORE_DEPTH)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.operation  (operation),
		.rx_byte    (rx_byte),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata),
		.push       (push),
		.push_data  (push_data),
		.fifo_full  (fifo_full),
		.drain_done (drain_done)
	);

	fmr_cmd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (fifo_full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (fifo_empty)
	);

	fmr_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	fmr_back #(.STORE_DEPTH(STORE_DEPTH)) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.fifo_empty     (fifo_empty),
		.fifo_data      (pop_data),
		.fifo_pop       (pop),
		.ram_re         (ram_re),
		.ram_raddr      (ram_raddr),
		.ram_rdata      (ram_rdata),
		.drain_done     (drain_done),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.result_kind    (result_kind),
		.frame_done     (frame_done),
		.byte_dropped   (byte_dropped),
		.frame_overflow (frame_overflow),
		.message_byte   (message_byte),
		.byte_position  (byte_position),
		.is_local       (is_local),
		.last           (last)
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !fifo_full)
		else $error("command queue overrun");

	a_byte_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == fmr_pkg::KIND_BYTE |->
			!frame_done && !byte_dropped && !frame_overflow)
		else $error("status flags set on a message byte");

	a_drain_end: assert property (@(posedge clk) disable iff (!arst_n)
		drain_done |=> out_valid && last && result_kind == fmr_pkg::KIND_BYTE)
		else $error("drain ended without a final message byte");

	a_no_write_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		ram_re |-> !ram_we)
		else $error("store written during a drain");

endmodule
